### rtl/core/turtle_line_interpreter_unit_defines.svh
// Assertion macros for the turtle line interpreter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TURTLE_LINE_INTERPRETER_UNIT_DEFINES_SVH
`define TURTLE_LINE_INTERPRETER_UNIT_DEFINES_SVH

// same-cycle implication
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tli_pkg.sv
// Shared types, constants and the sine lookup for the turtle line interpreter.
// No dependencies.
package tli_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ANGLE_BITS  = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [ANGLE_BITS-1:0] HEAD_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [15:0] TURN_RESET = 16'd16384;

  localparam logic [7:0] SYM_DRAW_F = 8'h46;
  localparam logic [7:0] SYM_DRAW_A = 8'h41;
  localparam logic [7:0] SYM_DRAW_B = 8'h42;
  localparam logic [7:0] SYM_MOVE   = 8'h66;
  localparam logic [7:0] SYM_LEFT   = 8'h2B;
  localparam logic [7:0] SYM_RIGHT  = 8'h2D;
  localparam logic [7:0] SYM_PUSH   = 8'h5B;
  localparam logic [7:0] SYM_POP    = 8'h5D;

  typedef struct packed {
    logic [7:0] sym;
    logic       start;
  } tli_item_t;

  typedef struct packed {
    logic signed [31:0]    x;
    logic signed [31:0]    y;
    logic [ANGLE_BITS-1:0] h;
  } tli_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    tli_entry_t        data;
  } tli_wr_t;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic               ovf;
  } tli_seg_t;

  localparam logic [15:0] QSINE [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32767
  };

  // sine of an 8-bit angle, Q1.15
  function automatic logic signed [16:0] sine8(input logic [7:0] a);
    logic [6:0]  k;
    logic [15:0] v;
    k = {1'b0, a[5:0]};
    if (a[6]) k = 7'd64 - k;
    v = QSINE[k];
    sine8 = a[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) sat32 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sat32 = v[31:0];
  endfunction

endpackage

### rtl/core/tli_stack_mem.sv
// Saved-turtle stack memory: one write port, one registered read port,
// with write-to-read bypass. Depends on tli_pkg.
module tli_stack_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tli_pkg::ADDR_W-1:0] rd_addr,
  input  tli_pkg::tli_wr_t          wr,
  output tli_pkg::tli_entry_t       rd_data
);
  import tli_pkg::*;

  tli_entry_t mem [STACK_DEPTH];
  tli_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && (wr.addr == rd_addr)) rd_data_r <= wr.data;
      else rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/tli_exec.sv
// Turtle execute stage: position, heading, stack count and overflow flag,
// one symbol per fire. Depends on tli_pkg.
module tli_exec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  tli_pkg::tli_item_t        s1_item,
  input  logic                      fire,
  input  logic [15:0]               turn_angle,
  input  tli_pkg::tli_entry_t       pop_data,
  output logic                      draw,
  output tli_pkg::tli_seg_t         seg,
  output tli_pkg::tli_wr_t          wr,
  output logic [tli_pkg::CNT_W-1:0] cnt_after
);
  import tli_pkg::*;

  logic signed [31:0]    pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic [ANGLE_BITS-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;

  logic signed [31:0]    base_x, base_y, nx, ny;
  logic [ANGLE_BITS-1:0] base_h;
  logic [CNT_W-1:0]      base_cnt;
  logic                  base_ovf, push_ok;
  logic [7:0]            a8;
  logic signed [16:0]    sn, cs;
  logic signed [32:0]    sum_x, sum_y;

  always_comb begin
    base_x   = s1_item.start ? 32'sd0 : pos_x_r;
    base_y   = s1_item.start ? 32'sd0 : pos_y_r;
    base_h   = s1_item.start ? HEAD_QUARTER : head_r;
    base_cnt = s1_item.start ? '0 : cnt_r;
    base_ovf = s1_item.start ? 1'b0 : ovf_r;

    a8    = base_h[ANGLE_BITS-1 -: 8];
    sn    = sine8(a8);
    cs    = sine8(a8 + 8'd64);
    sum_x = {base_x[31], base_x} + {{15{cs[16]}}, cs, 1'b0};
    sum_y = {base_y[31], base_y} - {{15{sn[16]}}, sn, 1'b0};
    nx    = sat32(sum_x);
    ny    = sat32(sum_y);

    pos_x_nxt = base_x;
    pos_y_nxt = base_y;
    head_nxt  = base_h;
    cnt_nxt   = base_cnt;
    ovf_nxt   = base_ovf;
    push_ok   = 1'b0;
    draw      = 1'b0;

    unique case (s1_item.sym)
      SYM_DRAW_F, SYM_DRAW_A, SYM_DRAW_B: begin
        draw      = 1'b1;
        pos_x_nxt = nx;
        pos_y_nxt = ny;
      end
      SYM_MOVE: begin
        pos_x_nxt = nx;
        pos_y_nxt = ny;
      end
      SYM_LEFT:  head_nxt = base_h + ANGLE_BITS'(turn_angle);
      SYM_RIGHT: head_nxt = base_h - ANGLE_BITS'(turn_angle);
      SYM_PUSH: begin
        if (base_cnt < CNT_W'(STACK_DEPTH)) begin
          push_ok = 1'b1;
          cnt_nxt = base_cnt + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      SYM_POP: begin
        if (base_cnt != '0) begin
          cnt_nxt   = base_cnt - CNT_W'(1);
          pos_x_nxt = pop_data.x;
          pos_y_nxt = pop_data.y;
          head_nxt  = pop_data.h;
        end
      end
      default: ;
    endcase

    draw = draw && s1_valid;

    seg.from_x = base_x;
    seg.from_y = base_y;
    seg.to_x   = nx;
    seg.to_y   = ny;
    seg.ovf    = base_ovf;

    wr.we     = fire && push_ok;
    wr.addr   = base_cnt[ADDR_W-1:0];
    wr.data.x = base_x;
    wr.data.y = base_y;
    wr.data.h = base_h;

    cnt_after = s1_valid ? cnt_nxt : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      head_r  <= HEAD_QUARTER;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

### rtl/core/turtle_line_interpreter_unit.sv
// Turtle line interpreter, top level: input stage, execute stage, stack memory
// and output register. Depends on tli_pkg, tli_exec, tli_stack_mem and the
// assertion macro header.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one symbol beat with start_new.
//   Output channel (out_valid/out_stall) carries one segment beat for each
//   F, A or B symbol; other symbols give no beat.
//   Configuration channel (cfg_valid/cfg_ready) writes turn_angle; ready is
//   always high. Write only while the block is idle.
// A symbol beat is registered into execute, and its segment into the output
//   register when it fires. Throughput: one symbol per cycle while in_stall
//   is low. The stack pop read is issued as the symbol is taken, with the
//   address forwarded from the item ahead, so the position/heading loop closes in execute.
// Reset: turtle at (0,0) heading 90 degrees, stack empty, flag clear,
//   turn_angle 16384. The stack memory needs no clearing.
// Stall: while out_stall holds a segment, non-drawing symbols still pass; the
//   next drawing symbol waits in execute and in_stall rises until it moves.
module turtle_line_interpreter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_symbol,
  input  logic        in_start_new,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_from_x,
  output logic signed [31:0] out_from_y,
  output logic signed [31:0] out_to_x,
  output logic signed [31:0] out_to_y,
  output logic        out_stack_overflowed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_turn_angle
);
  import tli_pkg::*;
  `include "turtle_line_interpreter_unit_defines.svh"

  logic        s1_valid_r;
  tli_item_t   s1_item_r;
  logic [15:0] turn_r;
  logic        out_valid_r;
  tli_seg_t    out_seg_r;

  logic             accept, fire, draw, blocked;
  tli_seg_t         seg;
  tli_wr_t          wr;
  tli_entry_t       pop_data;
  logic [CNT_W-1:0] cnt_after;
  logic [ADDR_W-1:0] rd_addr;

  assign blocked   = draw && out_valid_r && out_stall;
  assign fire      = s1_valid_r && !blocked;
  assign in_stall  = s1_valid_r && blocked;
  assign accept    = in_valid && !in_stall;
  assign rd_addr   = ADDR_W'(cnt_after - CNT_W'(1));
  assign cfg_ready = 1'b1;

  tli_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_item    (s1_item_r),
    .fire       (fire),
    .turn_angle (turn_r),
    .pop_data   (pop_data),
    .draw       (draw),
    .seg        (seg),
    .wr         (wr),
    .cnt_after  (cnt_after)
  );

  tli_stack_mem u_stack (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (pop_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      turn_r      <= TURN_RESET;
    end else begin
      if (accept) s1_valid_r <= 1'b1;
      else if (fire) s1_valid_r <= 1'b0;
      out_valid_r <= (out_valid_r && out_stall) || (fire && draw);
      if (cfg_valid && cfg_ready) turn_r <= cfg_turn_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.sym   <= in_symbol;
      s1_item_r.start <= in_start_new;
    end
    if (fire && draw) out_seg_r <= seg;
  end

  assign out_valid            = out_valid_r;
  assign out_from_x           = out_seg_r.from_x;
  assign out_from_y           = out_seg_r.from_y;
  assign out_to_x             = out_seg_r.to_x;
  assign out_to_y             = out_seg_r.to_y;
  assign out_stack_overflowed = out_seg_r.ovf;

  `TLI_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall, "stall without a held beat")
  `TLI_ASSERT_NEXT(a_draw_loads, fire && draw, out_valid_r, "segment lost from execute")
  `TLI_ASSERT_NEXT(a_accept_fills, accept, s1_valid_r, "accepted symbol not in execute")

endmodule
